/* rtl/core/qau_pkg.sv */
// shared types, constants and helper functions of the quaternion arithmetic unit
`default_nettype none
package qau_pkg;
   localparam int FRAC_BITS = 24;
   localparam int DATA_W = 32;
   localparam int OPND_W = DATA_W + 1;
   localparam int ACC_W = 2 * OPND_W + 2;
   localparam int CFG_W = 31;
   localparam int CMD_W = 3;
   localparam int LANES = 4;
   localparam int LANE_W = 2;
   localparam int LEN_W = DATA_W + 1;
   localparam int NUM_W = DATA_W + FRAC_BITS;
   localparam int SQ_RAD_W = 2 * LEN_W;
   localparam int SQ_REM_W = LEN_W + 3;
   localparam int SQ_STEPS = LEN_W;
   localparam int SQ_CNT_W = $clog2(SQ_STEPS);
   localparam int DIV_CNT_W = $clog2(NUM_W);

   localparam logic [CMD_W-1:0] CMD_MUL = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SCALE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_NORM = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ROT = 3'd4;
   localparam logic [CMD_W-1:0] CMD_IROT = 3'd5;

   localparam logic [CFG_W-1:0] MIN_LENGTH_RESET = 31'd17;

   // 1.0 in the fixed-point format
   localparam logic signed [OPND_W-1:0] ONE_OPND = {{(OPND_W-1){1'b0}}, 1'b1} << FRAC_BITS;
   localparam logic signed [DATA_W-1:0] ONE_DATA = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;

   typedef struct packed {
      logic mul_valid;
      logic first;
      logic div_start;
      logic div_step;
   } lane_ctrl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] res;
      logic res_sat;
      logic signed [DATA_W-1:0] quo;
      logic quo_sat;
      logic [SQ_RAD_W-1:0] square;
   } lane_stat_type;

   // sign of term k of hamilton product component lane
   function automatic logic hneg(input logic [LANE_W-1:0] lane, input logic [LANE_W-1:0] k);
      logic r;
      case ({lane, k}) inside
         4'b0001, 4'b0010, 4'b0011, 4'b0111, 4'b1001, 4'b1110: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // index of the last multiply step of a command
   function automatic logic [LANE_W-1:0] last_step(input logic [CMD_W-1:0] cmd);
      logic [LANE_W-1:0] r;
      case (cmd) inside
         CMD_MUL, CMD_ROT, CMD_IROT: r = 2'd3;
         CMD_ADD: r = 2'd1;
         default: r = 2'd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

/* rtl/core/qau_lane.sv */
// one component lane: multiply-accumulate with rounding and clip, and a restoring divider
`default_nettype none
module qau_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  qau_pkg::lane_ctrl_type               ctrl,
   input  logic signed [qau_pkg::OPND_W-1:0]    x,
   input  logic signed [qau_pkg::OPND_W-1:0]    y,
   input  logic                                 neg,
   input  logic [qau_pkg::DATA_W-1:0]           mag,
   input  logic                                 mag_neg,
   input  logic [qau_pkg::LEN_W-1:0]            len,
   output qau_pkg::lane_stat_type               stat
);
   import qau_pkg::*;

   localparam int HI_W = NUM_W - DATA_W + 1;
   localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

   logic signed [2*OPND_W-1:0] prod_ff, prod_in;
   logic pneg_ff;
   logic acc_valid_ff, acc_first_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in, term, rnd;
   logic [NUM_W-1:0] dq_ff, dq_in;
   logic [LEN_W:0] dr_ff, dr_in, dr_sh;
   logic qneg_ff;
   logic [HI_W-1:0] q_hi;
   logic q_exact;

   assign prod_in = (2*OPND_W)'(x) * (2*OPND_W)'(y);
   assign term = pneg_ff ? -ACC_W'(prod_ff) : ACC_W'(prod_ff);
   assign acc_in = (acc_first_ff ? '0 : acc_ff) + term;

   // round half up, then clip to the data range
   assign rnd = (acc_ff + HALF) >>> FRAC_BITS;
   always_comb begin
      stat.res = rnd[DATA_W-1:0];
      stat.res_sat = 1'b0;
      if (!rnd[ACC_W-1] && (|rnd[ACC_W-2:DATA_W-1])) begin
         stat.res = {1'b0, {(DATA_W-1){1'b1}}};
         stat.res_sat = 1'b1;
      end else if (rnd[ACC_W-1] && !(&rnd[ACC_W-2:DATA_W-1])) begin
         stat.res = {1'b1, {(DATA_W-1){1'b0}}};
         stat.res_sat = 1'b1;
      end
   end
   assign stat.square = acc_ff[SQ_RAD_W-1:0];

   // divider step
   assign dr_sh = {dr_ff[LEN_W-1:0], dq_ff[NUM_W-1]};
   always_comb begin
      if (dr_sh >= {1'b0, len}) begin
         dr_in = dr_sh - {1'b0, len};
         dq_in = {dq_ff[NUM_W-2:0], 1'b1};
      end else begin
         dr_in = dr_sh;
         dq_in = {dq_ff[NUM_W-2:0], 1'b0};
      end
   end

   // signed quotient with clip
   assign q_hi = dq_ff[NUM_W-1:DATA_W-1];
   assign q_exact = (q_hi == {{(HI_W-1){1'b0}}, 1'b1}) && (dq_ff[DATA_W-2:0] == '0);
   always_comb begin
      if (!qneg_ff) begin
         stat.quo_sat = |q_hi;
         stat.quo = stat.quo_sat ? {1'b0, {(DATA_W-1){1'b1}}} : dq_ff[DATA_W-1:0];
      end else begin
         stat.quo_sat = (|q_hi) && !q_exact;
         stat.quo = stat.quo_sat ? {1'b1, {(DATA_W-1){1'b0}}} : -dq_ff[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
         acc_first_ff <= 1'b0;
      end else begin
         acc_valid_ff <= ctrl.mul_valid;
         acc_first_ff <= ctrl.first;
      end
      if (ctrl.mul_valid) begin
         prod_ff <= prod_in;
         pneg_ff <= neg;
      end
      if (acc_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (ctrl.div_start) begin
         dq_ff <= (NUM_W'(mag) << FRAC_BITS) + NUM_W'(len >> 1);
         dr_ff <= '0;
         qneg_ff <= mag_neg;
      end else if (ctrl.div_step) begin
         dq_ff <= dq_in;
         dr_ff <= dr_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/qau_sqrt.sv */
// iterative integer square root, two radicand bits per cycle
`default_nettype none
module qau_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [qau_pkg::SQ_RAD_W-1:0]      radicand,
   output logic                              done,
   output logic [qau_pkg::LEN_W-1:0]         root
);
   import qau_pkg::*;

   logic [SQ_RAD_W-1:0] rad_ff;
   logic [SQ_REM_W-1:0] rem_ff, shifted, trial;
   logic [LEN_W-1:0] root_ff;
   logic [SQ_CNT_W-1:0] cnt_ff;
   logic running_ff, done_ff;
   logic fits;

   assign shifted = {rem_ff[SQ_REM_W-3:0], rad_ff[SQ_RAD_W-1 -: 2]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign fits = shifted >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         running_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (running_ff) begin
         running_ff <= cnt_ff != SQ_CNT_W'(SQ_STEPS - 1);
         done_ff <= cnt_ff == SQ_CNT_W'(SQ_STEPS - 1);
      end else begin
         done_ff <= 1'b0;
      end
      if (start) begin
         rad_ff <= radicand;
         rem_ff <= '0;
         root_ff <= '0;
         cnt_ff <= '0;
      end else if (running_ff) begin
         rad_ff <= rad_ff << 2;
         rem_ff <= fits ? shifted - trial : shifted;
         root_ff <= {root_ff[LEN_W-2:0], fits};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

/* rtl/core/quaternion_arithmetic_unit.sv */
// top level of the quaternion arithmetic unit: sequencer, four lanes, merge and result register
//
// four lanes, one per result component, each with one 33x33 multiplier, work on an item side
// by side; a sequencer feeds them one product term per cycle outside the rotate wait. an item
// is taken when start is high and busy is low, and its result shows on the rsp_ ports for
// exactly one cycle marked by rsp_strobe; the receiver cannot stall, so results are never held
// back. scale and undefined commands issue one multiply step, add one per operand, multiply one
// per hamilton term (four per lane), rotate and inverse rotate two hamilton products with a wait
// for the first one to be rounded. after the last step results pass the product, accumulator and
// result registers. normalize keeps the unit busy: squares and their merge run through S_SQR,
// S_SQA and S_SUM, the shared square root takes two bits per cycle over a 66-bit radicand, then,
// unless it falls back to identity, the lane dividers take one quotient bit per cycle. a new item
// is taken in the cycle the previous one issues its last step. all arithmetic is exact up to one
// round-half-up per hamilton product (or half-away for normalize) and a clip to 32 bits that sets
// rsp_saturated. csr_write_data sets min_length; write it only while the unit is idle
`default_nettype none
module quaternion_arithmetic_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [qau_pkg::CMD_W-1:0]            req_command,
   input  logic signed [qau_pkg::DATA_W-1:0]    req_a_w,
   input  logic signed [qau_pkg::DATA_W-1:0]    req_a_x,
   input  logic signed [qau_pkg::DATA_W-1:0]    req_a_y,
   input  logic signed [qau_pkg::DATA_W-1:0]    req_a_z,
   input  logic signed [qau_pkg::DATA_W-1:0]    req_b_w,
   input  logic signed [qau_pkg::DATA_W-1:0]    req_b_x,
   input  logic signed [qau_pkg::DATA_W-1:0]    req_b_y,
   input  logic signed [qau_pkg::DATA_W-1:0]    req_b_z,
   input  logic signed [qau_pkg::DATA_W-1:0]    req_scale_factor,
   output logic                                 rsp_strobe,
   output logic signed [qau_pkg::DATA_W-1:0]    rsp_r_w,
   output logic signed [qau_pkg::DATA_W-1:0]    rsp_r_x,
   output logic signed [qau_pkg::DATA_W-1:0]    rsp_r_y,
   output logic signed [qau_pkg::DATA_W-1:0]    rsp_r_z,
   output logic                                 rsp_fell_back,
   output logic                                 rsp_saturated,
   input  logic                                 csr_write_enable,
   input  logic [qau_pkg::CFG_W-1:0]            csr_write_data
);
   import qau_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_GAP, S_SQR, S_SQA, S_SUM, S_SQRT, S_DIV, S_NFIN
   } state_type;

   // token that follows the last multiply step through accumulate and capture
   typedef struct packed {
      logic valid;
      logic to_t;
      logic rot;
   } fin_type;

   state_type state_ff, state_in;
   logic [LANE_W-1:0] step_ff, step_in;
   logic phase_ff, phase_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [CMD_W-1:0] cmd_ff;
   logic signed [DATA_W-1:0] a_ff [LANES];
   logic signed [DATA_W-1:0] b_ff [LANES];
   logic signed [DATA_W-1:0] t_ff [LANES];
   logic signed [DATA_W-1:0] s_ff;
   logic [CFG_W-1:0] min_length_ff;
   logic fb_ff, fb_in;
   logic sat1_ff;
   fin_type tok, fin1_ff, fin2_ff;

   logic strobe_ff;
   logic signed [DATA_W-1:0] r_ff [LANES];
   logic fell_back_ff, saturated_ff;

   logic is_rot, step_last, mul_last, accept, nfin;
   logic sq_start, sq_done, fallback;
   logic [LEN_W-1:0] sq_root;
   logic [SQ_RAD_W-1:0] sq_sum;
   lane_ctrl_type lctrl;
   lane_stat_type lstat [LANES];
   logic signed [OPND_W-1:0] x_sel [LANES];
   logic signed [OPND_W-1:0] y_sel [LANES];
   logic neg_sel [LANES];
   logic [DATA_W-1:0] mag_sel [LANES];
   logic res_sat_any, quo_sat_any;

   assign is_rot = (cmd_ff == CMD_ROT) || (cmd_ff == CMD_IROT);
   assign step_last = step_ff == last_step(cmd_ff);
   assign mul_last = (state_ff == S_MUL) && step_last && (!is_rot || phase_ff);
   assign nfin = state_ff == S_NFIN;
   // free again once the last step of the current item is out
   assign busy = !((state_ff == S_IDLE) || mul_last || nfin);
   assign accept = start && !busy;

   assign tok.valid = (state_ff == S_MUL) && step_last;
   assign tok.to_t = is_rot && !phase_ff;
   assign tok.rot = is_rot;

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      phase_in = phase_ff;
      dcnt_in = dcnt_ff;
      fb_in = fb_ff;
      sq_start = 1'b0;
      lctrl = '0;
      unique case (state_ff)
         S_IDLE: ;
         S_MUL: begin
            lctrl.mul_valid = 1'b1;
            lctrl.first = step_ff == '0;
            if (step_last) begin
               step_in = '0;
               if (is_rot && !phase_ff) begin
                  state_in = S_GAP;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_GAP: begin
            // wait for the first product to be rounded into t
            if (step_ff == 2'd1) begin
               step_in = '0;
               phase_in = 1'b1;
               state_in = S_MUL;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_SQR: begin
            lctrl.mul_valid = 1'b1;
            lctrl.first = 1'b1;
            state_in = S_SQA;
         end
         S_SQA: state_in = S_SUM;
         S_SUM: begin
            sq_start = 1'b1;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (sq_done) begin
               fb_in = fallback;
               dcnt_in = '0;
               if (fallback) begin
                  state_in = S_NFIN;
               end else begin
                  lctrl.div_start = 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            lctrl.div_step = 1'b1;
            if (dcnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
               state_in = S_NFIN;
            end else begin
               dcnt_in = dcnt_ff + 1'b1;
            end
         end
         S_NFIN: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (accept) begin
         step_in = '0;
         phase_in = 1'b0;
         state_in = (req_command == CMD_NORM) ? S_SQR : S_MUL;
      end
   end

   // operand selection: lane l takes term step of its component
   always_comb begin
      logic [LANE_W-1:0] j;
      logic [LANE_W-1:0] k;
      logic signed [OPND_W-1:0] a33 [LANES];
      logic signed [OPND_W-1:0] b33 [LANES];
      logic signed [OPND_W-1:0] c33 [LANES];
      logic signed [OPND_W-1:0] v33 [LANES];
      logic signed [OPND_W-1:0] t33 [LANES];
      k = step_ff;
      for (int i = 0; i < LANES; i++) begin
         a33[i] = OPND_W'(a_ff[i]);
         b33[i] = OPND_W'(b_ff[i]);
         t33[i] = OPND_W'(t_ff[i]);
         // conjugate and pure vector
         c33[i] = (i == 0) ? a33[i] : -a33[i];
         v33[i] = (i == 0) ? '0 : b33[i];
      end
      for (int l = 0; l < LANES; l++) begin
         j = LANE_W'(l) ^ k;
         x_sel[l] = '0;
         y_sel[l] = '0;
         neg_sel[l] = 1'b0;
         mag_sel[l] = a_ff[l][DATA_W-1] ? DATA_W'(-a_ff[l]) : DATA_W'(a_ff[l]);
         if (state_ff == S_SQR) begin
            x_sel[l] = a33[l];
            y_sel[l] = a33[l];
         end else begin
            case (cmd_ff) inside
               CMD_MUL: begin
                  x_sel[l] = a33[k];
                  y_sel[l] = b33[j];
                  neg_sel[l] = hneg(LANE_W'(l), k);
               end
               CMD_ADD: begin
                  x_sel[l] = (k == '0) ? a33[l] : b33[l];
                  y_sel[l] = ONE_OPND;
               end
               CMD_SCALE: begin
                  x_sel[l] = a33[l];
                  y_sel[l] = OPND_W'(s_ff);
               end
               CMD_ROT, CMD_IROT: begin
                  neg_sel[l] = hneg(LANE_W'(l), k);
                  if (!phase_ff) begin
                     x_sel[l] = (cmd_ff == CMD_ROT) ? c33[k] : a33[k];
                     y_sel[l] = v33[j];
                  end else begin
                     x_sel[l] = t33[k];
                     y_sel[l] = (cmd_ff == CMD_ROT) ? a33[j] : c33[j];
                  end
               end
               default: ;
            endcase
         end
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      qau_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (lctrl),
         .x       (x_sel[g]),
         .y       (y_sel[g]),
         .neg     (neg_sel[g]),
         .mag     (mag_sel[g]),
         .mag_neg (a_ff[g][DATA_W-1]),
         .len     (sq_root),
         .stat    (lstat[g])
      );
   end

   // merge: sum of squares into the root unit, flag reduction
   assign sq_sum = lstat[0].square + lstat[1].square + lstat[2].square + lstat[3].square;
   assign res_sat_any = lstat[0].res_sat | lstat[1].res_sat | lstat[2].res_sat | lstat[3].res_sat;
   assign quo_sat_any = lstat[0].quo_sat | lstat[1].quo_sat | lstat[2].quo_sat | lstat[3].quo_sat;
   // too short to normalize: zero length or below the configured minimum
   assign fallback = (sq_root == '0) || (sq_root < LEN_W'(min_length_ff));

   qau_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_sum),
      .done     (sq_done),
      .root     (sq_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         phase_ff <= 1'b0;
         dcnt_ff <= '0;
         fb_ff <= 1'b0;
         fin1_ff <= '0;
         fin2_ff <= '0;
         strobe_ff <= 1'b0;
         min_length_ff <= MIN_LENGTH_RESET;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         phase_ff <= phase_in;
         dcnt_ff <= dcnt_in;
         fb_ff <= fb_in;
         fin1_ff <= tok;
         fin2_ff <= fin1_ff;
         strobe_ff <= (fin2_ff.valid && !fin2_ff.to_t) || nfin;
         if (csr_write_enable) begin
            min_length_ff <= csr_write_data;
         end
      end
      if (accept) begin
         cmd_ff <= req_command;
         a_ff[0] <= req_a_w;
         a_ff[1] <= req_a_x;
         a_ff[2] <= req_a_y;
         a_ff[3] <= req_a_z;
         b_ff[0] <= req_b_w;
         b_ff[1] <= req_b_x;
         b_ff[2] <= req_b_y;
         b_ff[3] <= req_b_z;
         s_ff <= req_scale_factor;
      end
      // capture of rounded lane sums
      if (fin2_ff.valid) begin
         if (fin2_ff.to_t) begin
            for (int i = 0; i < LANES; i++) begin
               t_ff[i] <= lstat[i].res;
            end
            sat1_ff <= res_sat_any;
         end else begin
            r_ff[0] <= fin2_ff.rot ? '0 : lstat[0].res;
            for (int i = 1; i < LANES; i++) begin
               r_ff[i] <= lstat[i].res;
            end
            fell_back_ff <= 1'b0;
            saturated_ff <= res_sat_any | (fin2_ff.rot & sat1_ff);
         end
      end
      // capture of normalize result
      if (nfin) begin
         if (fb_ff) begin
            r_ff[0] <= ONE_DATA;
            for (int i = 1; i < LANES; i++) begin
               r_ff[i] <= '0;
            end
            saturated_ff <= 1'b0;
         end else begin
            for (int i = 0; i < LANES; i++) begin
               r_ff[i] <= lstat[i].quo;
            end
            saturated_ff <= quo_sat_any;
         end
         fell_back_ff <= fb_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_r_w = r_ff[0];
   assign rsp_r_x = r_ff[1];
   assign rsp_r_y = r_ff[2];
   assign rsp_r_z = r_ff[3];
   assign rsp_fell_back = fell_back_ff;
   assign rsp_saturated = saturated_ff;

`ifndef SYNTHESIS
   // a scale item always reports its result on rsp_strobe after it is taken
   a_scale_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == CMD_SCALE |=> ##3 rsp_strobe)
      else $error("scale item result missing");

   // the identity fallback is exact and never clipped
   a_fallback_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_fell_back |-> rsp_r_w == ONE_DATA && rsp_r_x == '0 &&
      rsp_r_y == '0 && rsp_r_z == '0 && !rsp_saturated)
      else $error("fallback result is not the identity");

   // normalize holds off further items
   a_norm_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == CMD_NORM |=> busy)
      else $error("normalize item did not hold busy");
`endif
endmodule
`default_nettype wire
